// ----- rtl/sbspr_pkg.sv -----
// Shared types and constants for the servo bus status packet receiver.
package sbspr_pkg;

  // Header sync byte and the longest run of results one packet may give.
  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam int         RUN_MAX   = 64;

  // Result status codes.
  localparam logic [2:0] STAT_OK     = 3'd0;
  localparam logic [2:0] STAT_HEADER = 3'd1;
  localparam logic [2:0] STAT_LONG   = 3'd2;
  localparam logic [2:0] STAT_FAULT  = 3'd3;
  localparam logic [2:0] STAT_SUM    = 3'd4;

  // Register index of buffer_capacity and its reset value.
  localparam logic       REG_CAPACITY = 1'b0;
  localparam logic [6:0] CAP_RESET    = 7'd64;

  // Receiver sequencer states.
  typedef enum logic [1:0] {
    S_HEAD,
    S_BODY,
    S_DRAIN
  } rx_state_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic [2:0] status;
    logic [6:0] packet_bytes;
  } result_t;

endpackage

// ----- rtl/sbspr_in_if.sv -----
// Input channel: one received serial byte with its fault flag.
interface sbspr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       rx_fault;

  modport source (output valid, output rx_byte, output rx_fault, input ready);
  modport sink (input valid, input rx_byte, input rx_fault, output ready);
endinterface

// ----- rtl/sbspr_out_if.sv -----
// Result channel: one packet byte or error report per transaction.
interface sbspr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic [2:0] status;
  logic [6:0] packet_bytes;

  modport source (output valid, output out_byte, output last, output status,
                  output packet_bytes, input ready);
  modport sink (input valid, input out_byte, input last, input status,
                input packet_bytes, output ready);
endinterface

// ----- rtl/servo_bus_status_packet_receiver.sv -----
// Status packet receiver: header check, byte store, checksum and result drain.
//
//   Channel  Direction  Handshake           Payload
//   in_ch    sink       valid/ready         rx_byte[7:0], rx_fault
//   out_ch   source     valid/ready         out_byte[7:0], last, status[2:0],
//                                           packet_bytes[6:0]
//   APB      slave      psel/penable/pready pwdata[6:0] -> buffer_capacity
//
// Bytes after the two sync bytes are written into the packet store as they arrive, but
// not a faulted byte or a rejected length byte. A good packet of n bytes is then read out
// of the store at one byte per cycle while out_ch does not stall; no input is taken meanwhile.
// An error result is registered at the edge that accepts its byte and is offered next cycle.
// Reset (synchronous, rst_n low) returns to header search; the store is not cleared.
// A stalled result stalls the input and the drain; nothing is lost.
module servo_bus_status_packet_receiver
  import sbspr_pkg::*;
#(
  parameter int STORE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  sbspr_in_if.sink    in_ch,
  sbspr_out_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int         LIM_MAX   = (STORE_DEPTH < RUN_MAX) ? STORE_DEPTH : RUN_MAX;
  localparam int         AW        = $clog2(LIM_MAX);
  localparam int         CW        = $clog2(LIM_MAX + 1);
  localparam logic [6:0] LIM_MAX_C = 7'(LIM_MAX);

  rx_state_t      state_r, state_nxt;
  logic [1:0]     hdr_cnt_r, hdr_cnt_nxt;
  logic           hdr_bad_r, hdr_bad_nxt;
  logic [CW-1:0]  wr_idx_r, wr_idx_nxt;
  logic [CW-1:0]  n_r, n_nxt;
  logic [7:0]     sum_r, sum_nxt;
  logic [CW-1:0]  rd_idx_r, rd_idx_nxt;
  logic           rd_pend_r, rd_pend_nxt;
  logic           rd_last_r, rd_last_nxt;
  logic [6:0]     cap_r;
  logic           out_valid_r;
  result_t        res_r;

  logic           out_free;
  logic           in_acc;
  logic [7:0]     rx_b;
  logic [6:0]     limit;
  logic [8:0]     len_n;
  logic           too_long;
  logic           sum_ok;
  logic           issue;
  logic           load;
  logic           err_load;
  logic [2:0]     err_code;
  logic           mem_wr_en;
  logic [AW-1:0]  mem_wr_addr;
  logic [7:0]     mem_rd_data;
  logic           cfg_wr;

  // Handshake and datapath terms.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r != S_DRAIN) && out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign rx_b        = in_ch.rx_byte;
  assign limit       = (cap_r > LIM_MAX_C) ? LIM_MAX_C : cap_r;
  assign len_n       = {1'b0, rx_b} + 9'd2;
  assign too_long    = len_n > {2'b00, limit};
  assign sum_ok      = (~sum_r == rx_b);
  assign issue       = (state_r == S_DRAIN) && (rd_idx_r != n_r) && (!rd_pend_r || out_free);
  assign load        = rd_pend_r && out_free;

  // Sequencer: header judgement, byte storage and drain control.
  always_comb begin
    state_nxt   = state_r;
    hdr_cnt_nxt = hdr_cnt_r;
    hdr_bad_nxt = hdr_bad_r;
    wr_idx_nxt  = wr_idx_r;
    n_nxt       = n_r;
    sum_nxt     = sum_r;
    rd_idx_nxt  = rd_idx_r;
    err_load    = 1'b0;
    err_code    = STAT_OK;
    mem_wr_en   = 1'b0;
    mem_wr_addr = wr_idx_r[AW-1:0];
    unique case (state_r)
      S_HEAD: begin
        if (in_acc) begin
          if (in_ch.rx_fault) begin
            err_load = 1'b1;
            err_code = STAT_FAULT;
          end else begin
            case (hdr_cnt_r) inside
              2'd0, 2'd1: begin
                if (rx_b != SYNC_BYTE) begin
                  hdr_bad_nxt = 1'b1;
                end
                hdr_cnt_nxt = hdr_cnt_r + 2'd1;
              end
              2'd2: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = AW'(0);
                sum_nxt     = rx_b;
                hdr_cnt_nxt = 2'd3;
              end
              default: begin
                if (hdr_bad_r) begin
                  err_load = 1'b1;
                  err_code = STAT_HEADER;
                end else if (too_long) begin
                  err_load = 1'b1;
                  err_code = STAT_LONG;
                end else begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = AW'(1);
                  sum_nxt     = sum_r + rx_b;
                  wr_idx_nxt  = CW'(2);
                  n_nxt       = CW'(len_n);
                  hdr_cnt_nxt = 2'd0;
                  hdr_bad_nxt = 1'b0;
                  if (rx_b == 8'd0) begin
                    // Zero length: the length byte is the checksum.
                    if (sum_ok) begin
                      state_nxt  = S_DRAIN;
                      rd_idx_nxt = '0;
                    end else begin
                      err_load = 1'b1;
                      err_code = STAT_SUM;
                    end
                  end else begin
                    state_nxt = S_BODY;
                  end
                end
              end
            endcase
          end
        end
      end
      S_BODY: begin
        if (in_acc) begin
          if (in_ch.rx_fault) begin
            err_load = 1'b1;
            err_code = STAT_FAULT;
          end else begin
            mem_wr_en  = 1'b1;
            wr_idx_nxt = wr_idx_r + CW'(1);
            sum_nxt    = sum_r + rx_b;
            if ((wr_idx_r + CW'(1)) == n_r) begin
              // Final byte: compare with the inverted sum of all before it.
              if (sum_ok) begin
                state_nxt  = S_DRAIN;
                rd_idx_nxt = '0;
              end else begin
                err_load = 1'b1;
                err_code = STAT_SUM;
              end
            end
          end
        end
      end
      S_DRAIN: begin
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
        end
        if (load && rd_last_r) begin
          state_nxt = S_HEAD;
        end
      end
      default: begin
        state_nxt = S_HEAD;
      end
    endcase
    // Any error drops the packet and restarts header search.
    if (err_load) begin
      state_nxt   = S_HEAD;
      hdr_cnt_nxt = 2'd0;
      hdr_bad_nxt = 1'b0;
    end
  end

  // Outstanding store read during the drain.
  always_comb begin
    rd_pend_nxt = rd_pend_r;
    rd_last_nxt = rd_last_r;
    if (issue) begin
      rd_pend_nxt = 1'b1;
      rd_last_nxt = (rd_idx_r == (n_r - CW'(1)));
    end else if (load) begin
      rd_pend_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_HEAD;
      hdr_cnt_r <= 2'd0;
      hdr_bad_r <= 1'b0;
      wr_idx_r  <= '0;
      n_r       <= '0;
      sum_r     <= 8'd0;
      rd_idx_r  <= '0;
      rd_pend_r <= 1'b0;
      rd_last_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      hdr_bad_r <= hdr_bad_nxt;
      wr_idx_r  <= wr_idx_nxt;
      n_r       <= n_nxt;
      sum_r     <= sum_nxt;
      rd_idx_r  <= rd_idx_nxt;
      rd_pend_r <= rd_pend_nxt;
      rd_last_r <= rd_last_nxt;
    end
  end

  // Packet store.
  sbspr_store #(
    .DEPTH (LIM_MAX)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (rx_b),
    .rd_en   (issue),
    .rd_addr (rd_idx_r[AW-1:0]),
    .rd_data (mem_rd_data)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load || err_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r.out_byte     <= mem_rd_data;
      res_r.last         <= rd_last_r;
      res_r.status       <= STAT_OK;
      res_r.packet_bytes <= 7'(n_r);
    end else if (err_load) begin
      res_r.out_byte     <= 8'd0;
      res_r.last         <= 1'b1;
      res_r.status       <= err_code;
      res_r.packet_bytes <= 7'd0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_byte     = res_r.out_byte;
  assign out_ch.last         = res_r.last;
  assign out_ch.status       = res_r.status;
  assign out_ch.packet_bytes = res_r.packet_bytes;

  // Configuration port.
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? {25'd0, cap_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= pwdata[6:0];
    end
  end

  // No byte is taken while a packet is being drained.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> !in_ch.ready)
    else $error("input accepted during drain");

  // An error result carries a zero byte, last set and no count.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.status != STAT_OK)) |->
      ((res_r.out_byte == 8'd0) && res_r.last && (res_r.packet_bytes == 7'd0)))
    else $error("malformed error result");

  // A store read is only outstanding while draining.
  assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == S_DRAIN))
    else $error("store read outside drain");

  // The write index stays inside the packet while the body is received.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BODY) |-> (wr_idx_r < n_r))
    else $error("write index beyond packet length");

  // A result that was not taken stays in the output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(out_valid_r) && !$past(out_ch.ready)) |-> (out_valid_r && $stable(res_r)))
    else $error("pending result changed");

endmodule

// ----- rtl/sbspr_store.sv -----
// Packet byte store: one write port and one registered read port.
module sbspr_store #(
  parameter int  DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- tb/sv/tb_servo_bus_status_packet_receiver.sv -----
// Self-checking testbench for the servo bus status packet receiver.
`timescale 1ns / 1ps

module tb_servo_bus_status_packet_receiver;
  import sbspr_pkg::*;

  localparam int          STORE_DEPTH = 64;
  localparam int          CYCLE_LIMIT = 2000000;
  localparam logic [2:0]  CAP_ADDR    = {REG_CAPACITY, 2'b00};

  // Flaws that the packet generator can build in.
  localparam int PK_GOOD    = 0;
  localparam int PK_BADSUM  = 1;
  localparam int PK_BADHEAD = 2;
  localparam int PK_FAULT   = 3;

  typedef struct {
    logic [7:0] data;
    logic       fault;
    bit         hold;
  } rx_item_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sbspr_in_if  in_ch ();
  sbspr_out_if out_ch ();

  servo_bus_status_packet_receiver #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Stimulus backlog, expected results and bookkeeping.
  rx_item_t rx_backlog[$];
  result_t  expected_results[$];
  int       rx_pushed       = 0;
  int       rx_accepted     = 0;
  int       mismatch_count  = 0;
  int       cycle_count     = 0;
  int       in_gap_max      = 0;
  int       out_stall_max   = 0;
  int       in_gap          = 0;
  int       out_stall       = 0;
  bit       in_taken        = 1'b0;
  bit       out_taken       = 1'b0;

  // Shadow copy of the receiver state.
  logic [6:0] capacity_copy = CAP_RESET;
  logic [1:0] hdr_count     = 2'd0;
  logic       hdr_bad       = 1'b0;
  logic       in_body       = 1'b0;
  logic [6:0] wr_idx        = 7'd0;
  logic [7:0] body_left     = 8'd0;
  logic [7:0] byte_sum      = 8'd0;
  logic [7:0] packet_copy [STORE_DEPTH];

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int capacity_limit();
    int lim;
    lim = int'(capacity_copy);
    if (lim > STORE_DEPTH) lim = STORE_DEPTH;
    if (lim > RUN_MAX) lim = RUN_MAX;
    return lim;
  endfunction

  function automatic result_t make_result(logic [7:0] b, logic l, logic [2:0] s,
                                          logic [6:0] n);
    result_t r;
    r.out_byte     = b;
    r.last         = l;
    r.status       = s;
    r.packet_bytes = n;
    return r;
  endfunction

  function automatic void drop_packet();
    hdr_count = 2'd0;
    hdr_bad   = 1'b0;
    in_body   = 1'b0;
    wr_idx    = 7'd0;
    body_left = 8'd0;
    byte_sum  = 8'd0;
  endfunction

  function automatic void expect_error(logic [2:0] code);
    expected_results.push_back(make_result(8'h00, 1'b1, code, 7'd0));
    drop_packet();
  endfunction

  // Checksum check on a complete packet, then either the byte run or one error.
  function automatic void close_packet();
    int         n;
    logic [7:0] chk;
    logic [7:0] before_chk;
    n = int'(wr_idx);
    if (n < 2 || n > STORE_DEPTH) begin
      expect_error(STAT_SUM);
      return;
    end
    chk        = packet_copy[n-1];
    before_chk = byte_sum - chk;
    if (~before_chk != chk) begin
      expect_error(STAT_SUM);
      return;
    end
    for (int k = 0; k < n; k++) begin
      expected_results.push_back(make_result(packet_copy[k], k == n - 1, STAT_OK, 7'(n)));
    end
    drop_packet();
  endfunction

  // Advance the shadow receiver by one accepted byte.
  function automatic void predict_rx_byte(logic [7:0] b, logic fault);
    int n;
    if (fault) begin
      expect_error(STAT_FAULT);
      return;
    end
    if (!in_body) begin
      case (hdr_count)
        2'd0, 2'd1: begin
          if (b != SYNC_BYTE) hdr_bad = 1'b1;
          hdr_count = hdr_count + 2'd1;
        end
        2'd2: begin
          packet_copy[0] = b;
          hdr_count = 2'd3;
        end
        default: begin
          n = int'(b) + 2;
          if (hdr_bad) begin
            expect_error(STAT_HEADER);
          end else if (n > capacity_limit()) begin
            expect_error(STAT_LONG);
          end else begin
            packet_copy[1] = b;
            byte_sum  = packet_copy[0] + b;
            wr_idx    = 7'd2;
            body_left = b;
            hdr_count = 2'd0;
            if (body_left == 8'd0) close_packet();
            else in_body = 1'b1;
          end
        end
      endcase
      return;
    end
    if (wr_idx >= STORE_DEPTH || body_left == 8'd0) begin
      expect_error(STAT_LONG);
      return;
    end
    packet_copy[wr_idx] = b;
    wr_idx    = wr_idx + 7'd1;
    byte_sum  = byte_sum + b;
    body_left = body_left - 8'd1;
    if (body_left == 8'd0) close_packet();
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Monitor: register writes, accepted input transactions and result transactions.
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (psel && penable && pwrite && pready && paddr == CAP_ADDR) begin
        capacity_copy = pwdata[6:0];
      end
      in_taken = in_ch.valid && in_ch.ready;
      if (in_taken) begin
        predict_rx_byte(in_ch.rx_byte, in_ch.rx_fault);
        rx_accepted++;
      end
      out_taken = out_ch.valid && out_ch.ready;
      if (out_taken) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: out_byte %0h status %0d", out_ch.out_byte,
                 out_ch.status);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("out_byte", int'(want.out_byte), int'(out_ch.out_byte));
          check_field("last", int'(want.last), int'(out_ch.last));
          check_field("status", int'(want.status), int'(out_ch.status));
          check_field("packet_bytes", int'(want.packet_bytes), int'(out_ch.packet_bytes));
        end
      end
    end
  end

  // Input driver: holds each byte until accepted, then idles a drawn number of cycles.
  always @(negedge clk) begin
    rx_item_t nx;
    logic     nv;
    if (rst_n && !(in_ch.valid && !in_taken)) begin
      nv = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (rx_backlog.size() > 0 &&
                   !(rx_backlog[0].hold && expected_results.size() != 0)) begin
        nx = rx_backlog.pop_front();
        in_ch.rx_byte  <= nx.data;
        in_ch.rx_fault <= nx.fault;
        nv = 1'b1;
        in_gap = $urandom_range(0, in_gap_max);
      end
      in_ch.valid <= nv;
    end
  end

  // Result sink: stalls a drawn number of cycles after each transaction.
  always @(negedge clk) begin
    logic nr;
    if (rst_n) begin
      if (out_taken) out_stall = $urandom_range(0, out_stall_max);
      if (out_stall > 0) begin
        nr = 1'b0;
        out_stall--;
      end else begin
        nr = 1'b1;
      end
      out_ch.ready <= nr;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_servo_bus_status_packet_receiver: FAIL");
      $finish;
    end
  end

  task automatic push_rx(input logic [7:0] b, input logic f, input bit hold);
    rx_item_t it;
    it.data  = b;
    it.fault = f;
    it.hold  = hold;
    rx_backlog.push_back(it);
    rx_pushed++;
  endtask

  // Build one packet; packets rejected at the header stop after four bytes.
  task automatic add_packet(input int len, input int flaw, input bit hold, output int count);
    logic [7:0] id;
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] h0;
    logic [7:0] h1;
    int         total;
    int         fault_at;
    id = 8'($urandom_range(0, 255));
    if (len == 0) id = (flaw == PK_BADSUM) ? 8'($urandom_range(0, 254)) : SYNC_BYTE;
    h0 = SYNC_BYTE;
    h1 = SYNC_BYTE;
    if (flaw == PK_BADHEAD) begin
      if ($urandom_range(0, 1)) h0 = 8'($urandom_range(0, 254));
      else h1 = 8'($urandom_range(0, 254));
    end
    total = 4 + len;
    if (flaw == PK_BADHEAD || len + 2 > capacity_limit()) total = 4;
    fault_at = (flaw == PK_FAULT) ? $urandom_range(0, total - 1) : -1;
    sum = id + 8'(len);
    count = 0;
    for (int k = 0; k < total; k++) begin
      if (k == 0) b = h0;
      else if (k == 1) b = h1;
      else if (k == 2) b = id;
      else if (k == 3) b = 8'(len);
      else if (k == total - 1) begin
        b = ~sum;
        if (flaw == PK_BADSUM) b = b ^ 8'($urandom_range(1, 255));
      end else begin
        b = 8'($urandom_range(0, 255));
        sum = sum + b;
      end
      if (k == fault_at) b = 8'($urandom_range(0, 255));
      push_rx(b, k == fault_at, hold && k == 0);
      count++;
      if (k == fault_at) break;
    end
  endtask

  // Mostly well-formed packets with random content, some flawed ones and junk.
  task automatic add_random_traffic(input int budget);
    int added;
    int pick;
    int len;
    int flaw;
    int count;
    added = 0;
    while (added < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        for (int k = 0; k < 4; k++) begin
          push_rx(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b0);
        end
        added += 4;
      end else begin
        if (pick < 76) flaw = PK_GOOD;
        else if (pick < 84) flaw = PK_BADSUM;
        else if (pick < 92) flaw = PK_BADHEAD;
        else flaw = PK_FAULT;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 6);
        add_packet(len, flaw, $urandom_range(0, 7) == 0, count);
        added += count;
      end
    end
  endtask

  task automatic wait_idle();
    while (rx_accepted != rx_pushed || expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [6:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_phase(input logic [6:0] cap, input int gap_in, input int stall_out,
                           input int budget);
    wait_idle();
    write_capacity(cap);
    in_gap_max    = gap_in;
    out_stall_max = stall_out;
    add_random_traffic(budget);
  endtask

  initial begin
    int count;
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_ch.valid    = 1'b0;
    in_ch.rx_byte  = '0;
    in_ch.rx_fault = 1'b0;
    out_ch.ready   = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at full capacity.
    write_capacity(7'd64);
    in_gap_max    = 4;
    out_stall_max = 4;
    // Zero length with id 0xFF passes; with another id the checksum fails.
    push_rx(8'hFF, 1'b0, 1'b0); push_rx(8'hFF, 1'b0, 1'b0);
    push_rx(8'hFF, 1'b0, 1'b0); push_rx(8'h00, 1'b0, 1'b0);
    push_rx(8'hFF, 1'b0, 1'b0); push_rx(8'hFF, 1'b0, 1'b0);
    push_rx(8'h05, 1'b0, 1'b0); push_rx(8'h00, 1'b0, 1'b0);
    // Bad first header byte.
    push_rx(8'hFE, 1'b0, 1'b0); push_rx(8'hFF, 1'b0, 1'b0);
    push_rx(8'h01, 1'b0, 1'b0); push_rx(8'h02, 1'b0, 1'b0);
    // Receive fault on a header byte.
    push_rx(8'h00, 1'b1, 1'b0);
    // Good two-byte body after all results have drained.
    push_rx(8'hFF, 1'b0, 1'b1); push_rx(8'hFF, 1'b0, 1'b0);
    push_rx(8'h00, 1'b0, 1'b0); push_rx(8'h02, 1'b0, 1'b0);
    push_rx(8'h00, 1'b0, 1'b0); push_rx(8'hFD, 1'b0, 1'b0);
    // Receive fault inside the body.
    push_rx(8'hFF, 1'b0, 1'b0); push_rx(8'hFF, 1'b0, 1'b0);
    push_rx(8'h01, 1'b0, 1'b0); push_rx(8'h03, 1'b0, 1'b0);
    push_rx(8'hAA, 1'b0, 1'b0); push_rx(8'hFF, 1'b1, 1'b0);
    wait_idle();
    in_gap_max    = 15;
    out_stall_max = 15;
    add_random_traffic(6);

    // Smallest usable capacity: one body byte is already too long.
    wait_idle();
    write_capacity(7'd2);
    add_packet(1, PK_GOOD, 1'b0, count);
    add_packet(0, PK_GOOD, 1'b0, count);
    add_random_traffic(4);

    // All register bits set: the store depth is the limit.
    wait_idle();
    write_capacity(7'd127);
    in_gap_max    = 0;
    out_stall_max = 0;
    add_packet(62, PK_GOOD, 1'b0, count);
    add_packet(63, PK_GOOD, 1'b0, count);

    // Capacities below two reject every packet.
    run_phase(7'd1, 15, 0, 4);
    run_phase(7'd0, 0, 15, 4);
    run_phase(7'($urandom_range(3, 63)), 3, 3, 6);
    run_phase(7'd64, 15, 15, 8);

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_servo_bus_status_packet_receiver: PASS");
    end else begin
      $display("tb_servo_bus_status_packet_receiver: FAIL");
    end
    $finish;
  end

endmodule
